@@ hw/rtl/chxy_pkg.sv @@
// ============================================================================
// chxy_pkg
// Shared types, formats and the arctangent table for the compass heading unit.
// ============================================================================
`default_nettype none

package chxy_pkg;

    // stage count default and the table size
    localparam int CHXY_STAGES_DEF   = 16;
    localparam int CHXY_ATAN_ENTRIES = 24;

    // field and datapath widths
    localparam int BYTE_W    = 8;
    localparam int READ_W    = 2 * BYTE_W;
    localparam int PRE_SHIFT = 14;
    localparam int XY_W      = 34;
    localparam int Z_W       = 26;
    localparam int HEAD_W    = 16;
    localparam int RND_SHIFT = 9;
    localparam int H_W       = Z_W - RND_SHIFT;

    // angle constants in units of 2^-16 degree
    localparam logic signed [Z_W-1:0] HALF_TURN = 26'sd11796480;
    localparam logic signed [Z_W-1:0] RND_ADD   = 26'sd256;
    localparam logic signed [Z_W-1:0] WRAP_ADD  = 26'sd23593216;

    // full turn in output units of 1/128 degree
    localparam logic [H_W-1:0] OUT_FULL = 17'd46080;

    typedef logic signed [Z_W-1:0] chxy_angle_t;

    // vector state carried from stage to stage
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        chxy_angle_t            z;
        logic                   zero;
    } chxy_vec_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic chxy_angle_t chxy_atan(input int idx);
        chxy_angle_t a;
        case (idx)
            0:       a = 26'sd2949120;
            1:       a = 26'sd1740967;
            2:       a = 26'sd919879;
            3:       a = 26'sd466945;
            4:       a = 26'sd234379;
            5:       a = 26'sd117304;
            6:       a = 26'sd58666;
            7:       a = 26'sd29335;
            8:       a = 26'sd14668;
            9:       a = 26'sd7334;
            10:      a = 26'sd3667;
            11:      a = 26'sd1833;
            12:      a = 26'sd917;
            13:      a = 26'sd458;
            14:      a = 26'sd229;
            15:      a = 26'sd115;
            16:      a = 26'sd57;
            17:      a = 26'sd29;
            18:      a = 26'sd14;
            19:      a = 26'sd7;
            20:      a = 26'sd4;
            21:      a = 26'sd2;
            22:      a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/chxy_if.sv @@
// ============================================================================
// chxy_if
// Valid/ready channels for magnetometer samples and heading results.
// ============================================================================
`default_nettype none

interface chxy_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;

    modport source (output valid, x_high, x_low, y_high, y_low, input ready);
    modport sink   (input valid, x_high, x_low, y_high, y_low, output ready);
endinterface

interface chxy_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;

    modport source (output valid, heading, input ready);
    modport sink   (input valid, heading, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/compass_heading_from_xy_unit.sv @@
// Each sample is registered in chxy_prep, in each micro-rotation stage, then in chxy_post.
// Throughput: one sample per cycle; each stage has its own valid bit and advances
// whenever it is empty or its successor takes its item, so empty slots fill during stalls.
// The rate is set by the single micro-rotation per pipeline stage.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// ============================================================================
// compass_heading_from_xy_unit
// Pipelined CORDIC atan2 giving a compass heading in 1/128 degree units.
// ============================================================================
`default_nettype none

module compass_heading_from_xy_unit
    import chxy_pkg::*;
#(
    parameter int CORDIC_STAGES = CHXY_STAGES_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    chxy_sample_if.sink    sample,
    chxy_result_if.source  result
);

    // stages past the table end are not performed
    localparam int NSTG = (CORDIC_STAGES < CHXY_ATAN_ENTRIES) ? CORDIC_STAGES
                                                              : CHXY_ATAN_ENTRIES;

    chxy_vec_t stg_vec   [NSTG+1];
    logic      stg_valid [NSTG+1];
    logic      stg_ready [NSTG+1];

    // input stage
    chxy_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .x_high    (sample.x_high),
        .x_low     (sample.x_low),
        .y_high    (sample.y_high),
        .y_low     (sample.y_low),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_vec   (stg_vec[0])
    );

    // micro-rotation chain
    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        chxy_cordic_stage #(
            .IDX (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_vec    (stg_vec[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_vec   (stg_vec[k+1])
        );
    end

    // output stage
    chxy_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[NSTG]),
        .in_ready  (stg_ready[NSTG]),
        .in_vec    (stg_vec[NSTG]),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .heading   (result.heading)
    );

endmodule

`default_nettype wire

@@ hw/rtl/chxy_prep.sv @@
// ============================================================================
// chxy_prep
// Joins the reading bytes, scales them and folds the left half plane.
// ============================================================================
`default_nettype none

module chxy_prep
    import chxy_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] x_high,
    input  wire logic [BYTE_W-1:0] x_low,
    input  wire logic [BYTE_W-1:0] y_high,
    input  wire logic [BYTE_W-1:0] y_low,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output chxy_vec_t              out_vec
);

    logic        valid_reg;
    chxy_vec_t   vec_reg;
    chxy_vec_t   vec_next;

    logic signed [READ_W-1:0] xr;
    logic signed [READ_W-1:0] yr;
    logic signed [XY_W-1:0]   xs;
    logic signed [XY_W-1:0]   ys;

    // join big-endian and scale by 2^14
    always_comb
    begin
        xr = $signed({x_high, x_low});
        yr = $signed({y_high, y_low});
        xs = $signed({{(XY_W-READ_W-PRE_SHIFT){xr[READ_W-1]}}, xr, {PRE_SHIFT{1'b0}}});
        ys = $signed({{(XY_W-READ_W-PRE_SHIFT){yr[READ_W-1]}}, yr, {PRE_SHIFT{1'b0}}});
    end

    // if x is negative, negate into the right half plane and start at 180 degrees, else at 0
    always_comb
    begin
        vec_next.zero = (xr == '0) && (yr == '0);
        if (xr[READ_W-1])
        begin
            vec_next.x = -xs;
            vec_next.y = -ys;
            vec_next.z = HALF_TURN;
        end
        else
        begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chxy_cordic_stage.sv @@
// ============================================================================
// chxy_cordic_stage
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ============================================================================
`default_nettype none

module chxy_cordic_stage
    import chxy_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire chxy_vec_t in_vec,
    output logic           out_valid,
    input  wire logic      out_ready,
    output chxy_vec_t      out_vec
);

    logic        valid_reg;
    chxy_vec_t   vec_reg;
    chxy_vec_t   vec_next;

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   y_pos;

    // rotate toward the x axis; arithmetic shift rounds toward minus infinity
    always_comb
    begin
        x_in  = in_vec.x;
        y_in  = in_vec.y;
        dx    = y_in >>> IDX;
        dy    = x_in >>> IDX;
        y_pos = !y_in[XY_W-1] && (y_in != '0);
        vec_next.zero = in_vec.zero;
        if (y_pos)
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = in_vec.z + chxy_atan(IDX);
        end
        else
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = in_vec.z - chxy_atan(IDX);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chxy_post.sv @@
// ============================================================================
// chxy_post
// Normalizes the angle, rounds to 1/128 degree and wraps a full turn.
// ============================================================================
`default_nettype none

module chxy_post
    import chxy_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire chxy_vec_t         in_vec,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [HEAD_W-1:0]      heading
);

    logic              valid_reg;
    logic [HEAD_W-1:0] heading_reg;
    logic [HEAD_W-1:0] heading_next;

    chxy_angle_t       z_sum;
    logic [H_W-1:0]    h_raw;
    logic [H_W-1:0]    h_wrap;

    // add a full turn when negative and the rounding half in one adder
    always_comb
    begin
        if (in_vec.z[Z_W-1])
            z_sum = in_vec.z + WRAP_ADD;
        else
            z_sum = in_vec.z + RND_ADD;
        h_raw  = z_sum[Z_W-1:RND_SHIFT];
        h_wrap = (h_raw >= OUT_FULL) ? (h_raw - OUT_FULL) : h_raw;
        heading_next = in_vec.zero ? '0 : h_wrap[HEAD_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            heading_reg <= heading_next;
    end

    assign out_valid = valid_reg;
    assign heading   = heading_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chxy_checker.sv @@
// ============================================================================
// chxy_checker
// Port-level assertions for the compass heading unit, bound to the top level.
// ============================================================================
`default_nettype none

module chxy_checker
    import chxy_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    input  wire logic              sample_ready,
    input  wire logic              result_valid,
    input  wire logic              result_ready,
    input  wire logic [HEAD_W-1:0] heading
);

    localparam int CNT_W = 6;

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             take_in;
    logic             take_out;

    // items accepted but not yet delivered
    always_comb
    begin
        take_in  = sample_valid && sample_ready;
        take_out = result_valid && result_ready;
        inflight_next = inflight_reg;
        if (take_in && !take_out)
            inflight_next = inflight_reg + CNT_W'(1);
        else if (take_out && !take_in)
            inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // heading always below a full turn
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (heading < HEAD_W'(OUT_FULL)))
        else $error("heading out of range");

    // a ready sink means the whole pipeline can advance
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("sample not taken while result side ready");

    // no result without an item in flight
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (inflight_reg != '0))
        else $error("result with no item in flight");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(heading)))
        else $error("stalled result changed");

endmodule

bind compass_heading_from_xy_unit chxy_checker u_chxy_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .heading      (result.heading)
);

`default_nettype wire
